FILE: hw/rtl/tasgr_pkg.sv
// Shared types, character codes and the color table for the attribute-to-SGR block.
`default_nettype none
package tasgr_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANSI_ENABLED  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TERMINAL_KIND = 1'd1;
   localparam int unsigned CSR_DATA_W = 2;

   // Terminal kinds
   localparam logic [1:0] KIND_OTHER     = 2'd0;
   localparam logic [1:0] KIND_UNDERLINE = 2'd1;
   localparam logic [1:0] KIND_ITALIC    = 2'd2;

   // Attribute field masks
   localparam logic [7:0] ATTR_FG_MASK     = 8'h07;
   localparam logic [7:0] ATTR_BG_MASK     = 8'h70;
   localparam logic [7:0] ATTR_BRIGHT_MASK = 8'h08;
   localparam logic [7:0] ATTR_BLINK_MASK  = 8'h80;
   localparam logic [7:0] ATTR_MODE_MASK   = 8'h88;

   // ASCII codes
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LBR   = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_FOUR  = 8'h34;
   localparam logic [7:0] CH_FIVE  = 8'h35;

   // Parameter slots of one sequence, emitted lowest first
   localparam int unsigned SLOT_ZERO  = 0;
   localparam int unsigned SLOT_FG    = 1;
   localparam int unsigned SLOT_BG    = 2;
   localparam int unsigned SLOT_BOLD  = 3;
   localparam int unsigned SLOT_PRE   = 4;
   localparam int unsigned SLOT_BLINK = 5;
   localparam int unsigned NUM_SLOTS  = 6;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] slots;
      logic                 pre_three;
      logic [2:0]           fg_ansi;
      logic [2:0]           bg_ansi;
   } seq_desc_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LBR,
      BK_SEP,
      BK_TENS,
      BK_ONES,
      BK_END
   } back_state_type;

   // IBM color number to ANSI color number
   function automatic logic [2:0] ibm_to_ansi(input logic [2:0] ibm);
      logic [2:0] res;
      case (ibm)
         3'd0: res = 3'd0;
         3'd1: res = 3'd4;
         3'd2: res = 3'd2;
         3'd3: res = 3'd6;
         3'd4: res = 3'd1;
         3'd5: res = 3'd5;
         3'd6: res = 3'd3;
         3'd7: res = 3'd7;
         default: res = 3'd0;
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tasgr_front.sv
// Front end: configuration registers and classification of attribute changes.
`default_nettype none
module tasgr_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [tasgr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tasgr_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                             accept,
   input  wire logic [7:0]                       new_attr,
   input  wire logic [7:0]                       current_attr,
   input  wire logic                             force_req,
   output      logic                             q_push,
   output      tasgr_pkg::seq_desc_type          q_desc
);

   logic       ansi_enabled_ff, ansi_enabled_in;
   logic [1:0] terminal_kind_ff, terminal_kind_in;
   logic [7:0] diff;
   logic       mode_change;
   logic       blink_set;
   logic       has_pre;

   assign csr_ready = 1'b1;

   always_comb begin
      ansi_enabled_in  = ansi_enabled_ff;
      terminal_kind_in = terminal_kind_ff;
      if (csr_valid) begin
         case (csr_index)
            tasgr_pkg::CSR_ANSI_ENABLED:  ansi_enabled_in  = csr_data[0];
            tasgr_pkg::CSR_TERMINAL_KIND: terminal_kind_in = csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ansi_enabled_ff  <= 1'b1;
         terminal_kind_ff <= tasgr_pkg::KIND_OTHER;
      end else begin
         ansi_enabled_ff  <= ansi_enabled_in;
         terminal_kind_ff <= terminal_kind_in;
      end
   end

   assign diff        = new_attr ^ current_attr;
   assign mode_change = |(diff & tasgr_pkg::ATTR_MODE_MASK);
   assign blink_set   = |(new_attr & tasgr_pkg::ATTR_BLINK_MASK);
   assign has_pre     = (terminal_kind_ff == tasgr_pkg::KIND_UNDERLINE) ||
                        (terminal_kind_ff == tasgr_pkg::KIND_ITALIC);

   always_comb begin
      q_desc           = '0;
      q_desc.fg_ansi   = tasgr_pkg::ibm_to_ansi(new_attr[2:0]);
      q_desc.bg_ansi   = tasgr_pkg::ibm_to_ansi(new_attr[6:4]);
      q_desc.pre_three = (terminal_kind_ff == tasgr_pkg::KIND_ITALIC);
      if (mode_change) begin
         // Full reset: colors resent, then bright/blink counted from cleared
         q_desc.slots[tasgr_pkg::SLOT_ZERO]  = 1'b1;
         q_desc.slots[tasgr_pkg::SLOT_FG]    = 1'b1;
         q_desc.slots[tasgr_pkg::SLOT_BG]    = 1'b1;
         q_desc.slots[tasgr_pkg::SLOT_BOLD]  = |(new_attr & tasgr_pkg::ATTR_BRIGHT_MASK);
         q_desc.slots[tasgr_pkg::SLOT_PRE]   = blink_set && has_pre;
         q_desc.slots[tasgr_pkg::SLOT_BLINK] = blink_set;
      end else begin
         q_desc.slots[tasgr_pkg::SLOT_FG] = |(diff & tasgr_pkg::ATTR_FG_MASK);
         q_desc.slots[tasgr_pkg::SLOT_BG] = |(diff & tasgr_pkg::ATTR_BG_MASK);
      end
   end

   assign q_push = accept && (diff != 8'h00) && (ansi_enabled_ff || force_req);

endmodule
`default_nettype wire

FILE: hw/rtl/tasgr_queue.sv
// Small descriptor queue between the front end and the byte sequencer.
`default_nettype none
module tasgr_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire tasgr_pkg::seq_desc_type wr_data,
   input  wire logic                    pop,
   output      tasgr_pkg::seq_desc_type rd_data,
   output      logic                    full,
   output      logic                    empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   tasgr_pkg::seq_desc_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/tasgr_back.sv
// Back end: walks one descriptor and emits the escape sequence one byte per cycle while rsp_pop drains it.
`default_nettype none
module tasgr_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_empty,
   input  wire tasgr_pkg::seq_desc_type q_desc,
   output      logic                    q_pop,
   output      logic                    rsp_empty,
   input  wire logic                    rsp_pop,
   output      logic [7:0]              rsp_out_byte,
   output      logic                    rsp_last
);

   localparam int unsigned NS = tasgr_pkg::NUM_SLOTS;

   tasgr_pkg::back_state_type state_ff, state_in;
   tasgr_pkg::seq_desc_type   desc_ff, desc_in;
   logic [NS-1:0] slots_ff, slots_in;
   logic [NS-1:0] low;
   logic [NS-1:0] rest;
   logic          two_digit;
   logic [2:0]    ones_val;
   logic          advance;
   logic          emit;
   logic [7:0]    emit_byte;
   logic          emit_last;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;

   // Output register: a new byte may enter whenever it is empty or the old one leaves
   assign advance      = !out_valid_ff || rsp_pop;
   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;

   // Lowest pending parameter slot
   assign low       = slots_ff & (~slots_ff + NS'(1));
   assign rest      = slots_ff & ~low;
   assign two_digit = low[tasgr_pkg::SLOT_FG] || low[tasgr_pkg::SLOT_BG];

   always_comb begin
      ones_val = 3'd0;
      if (low[tasgr_pkg::SLOT_FG]) begin
         ones_val = desc_ff.fg_ansi;
      end else if (low[tasgr_pkg::SLOT_BG]) begin
         ones_val = desc_ff.bg_ansi;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tasgr_pkg::BK_IDLE: if (advance && !q_empty) state_in = tasgr_pkg::BK_LBR;
         tasgr_pkg::BK_LBR,
         tasgr_pkg::BK_SEP: begin
            if (advance) state_in = two_digit ? tasgr_pkg::BK_TENS : tasgr_pkg::BK_ONES;
         end
         tasgr_pkg::BK_TENS: if (advance) state_in = tasgr_pkg::BK_ONES;
         tasgr_pkg::BK_ONES: begin
            if (advance) state_in = (rest != '0) ? tasgr_pkg::BK_SEP : tasgr_pkg::BK_END;
         end
         tasgr_pkg::BK_END: if (advance) state_in = tasgr_pkg::BK_IDLE;
         default: state_in = tasgr_pkg::BK_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      emit      = 1'b0;
      emit_byte = tasgr_pkg::CH_ESC;
      emit_last = 1'b0;
      q_pop     = 1'b0;
      case (state_ff)
         tasgr_pkg::BK_IDLE: begin
            emit  = advance && !q_empty;
            q_pop = advance && !q_empty;
         end
         tasgr_pkg::BK_LBR: begin
            emit      = advance;
            emit_byte = tasgr_pkg::CH_LBR;
         end
         tasgr_pkg::BK_SEP: begin
            emit      = advance;
            emit_byte = tasgr_pkg::CH_SEMI;
         end
         tasgr_pkg::BK_TENS: begin
            emit      = advance;
            emit_byte = low[tasgr_pkg::SLOT_FG] ? tasgr_pkg::CH_THREE : tasgr_pkg::CH_FOUR;
         end
         tasgr_pkg::BK_ONES: begin
            emit = advance;
            if (low[tasgr_pkg::SLOT_BOLD]) begin
               emit_byte = tasgr_pkg::CH_ONE;
            end else if (low[tasgr_pkg::SLOT_PRE]) begin
               emit_byte = desc_ff.pre_three ? tasgr_pkg::CH_THREE : tasgr_pkg::CH_FOUR;
            end else if (low[tasgr_pkg::SLOT_BLINK]) begin
               emit_byte = tasgr_pkg::CH_FIVE;
            end else begin
               emit_byte = tasgr_pkg::CH_ZERO | {5'd0, ones_val};
            end
         end
         tasgr_pkg::BK_END: begin
            emit      = advance;
            emit_byte = tasgr_pkg::CH_M;
            emit_last = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      desc_in  = desc_ff;
      slots_in = slots_ff;
      if (q_pop) begin
         desc_in  = q_desc;
         slots_in = q_desc.slots;
      end else if (state_ff == tasgr_pkg::BK_ONES && advance) begin
         slots_in = rest;
      end
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = emit;
         out_byte_in  = emit_byte;
         out_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tasgr_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
         slots_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         slots_ff     <= slots_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/text_attribute_to_ansi_sgr.sv
// Top level: IBM text attribute change to ANSI SGR escape sequence byte stream.
//
//  channel   handshake          payload
//  req_      req_push/req_full  req_new_attr[7:0] req_current_attr[7:0] req_force_req
//  rsp_      rsp_empty/rsp_pop  rsp_out_byte[7:0] rsp_last
//  csr_      csr_valid/csr_ready csr_index[0] csr_data[1:0]
//
// Items are classified and queued in the cycle they are accepted, one per cycle
// while the descriptor queue has room. The back-end sequencer sends one byte per
// cycle whenever its output register is free; a sequence is 5 to 16 bytes long.
// Items with no change, or with ANSI off and no force, are not queued. Synchronous
// reset empties the queue and output register and restores ansi_enabled=1,
// terminal_kind=0. rsp_pop held low stalls the sequencer, then the queue fills
// and req_full rises.
`default_nettype none
module text_attribute_to_ansi_sgr #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output      logic                              req_full,
   input  wire logic [7:0]                        req_new_attr,
   input  wire logic [7:0]                        req_current_attr,
   input  wire logic                              req_force_req,
   output      logic                              rsp_empty,
   input  wire logic                              rsp_pop,
   output      logic [7:0]                        rsp_out_byte,
   output      logic                              rsp_last,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [tasgr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tasgr_pkg::CSR_DATA_W-1:0]  csr_data
);

   tasgr_pkg::seq_desc_type wr_desc, rd_desc;
   logic q_push, q_pop, q_full, q_empty;
   logic accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   tasgr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .accept       (accept),
      .new_attr     (req_new_attr),
      .current_attr (req_current_attr),
      .force_req    (req_force_req),
      .q_push       (q_push),
      .q_desc       (wr_desc)
   );

   tasgr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (wr_desc),
      .pop     (q_pop),
      .rd_data (rd_desc),
      .full    (q_full),
      .empty   (q_empty)
   );

   tasgr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_desc       (rd_desc),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
`default_nettype wire
